// File: hw/rtl/tsss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsss_pkg
// Shared widths, register indexes, reset values and status type for the serpentine stepper
// scan sequencer.
// ----------------------------------------------------------------------------
package tsss_pkg;

	localparam int PHASE_W     = 2;
	localparam int COIL_W      = 4;
	localparam int SWEEP_LIM_W = 11;
	localparam int ROW_LIM_W   = 12;
	localparam int POS_OUT_W   = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT   = 3'd5;

	localparam logic [COIL_W-1:0]      PATTERN0_RST    = 4'd1;
	localparam logic [COIL_W-1:0]      PATTERN1_RST    = 4'd2;
	localparam logic [COIL_W-1:0]      PATTERN2_RST    = 4'd4;
	localparam logic [COIL_W-1:0]      PATTERN3_RST    = 4'd8;
	localparam logic [SWEEP_LIM_W-1:0] SWEEP_LIMIT_RST = 11'd100;
	localparam logic [ROW_LIM_W-1:0]   ROW_LIMIT_RST   = 12'd50;

	typedef struct packed {
		logic               moving_right;
		logic               finished;
		logic [PHASE_W-1:0] bottom_phase;
		logic [PHASE_W-1:0] top_phase;
	} scan_flags_t;

endpackage
`default_nettype wire

// File: hw/rtl/tsss_scan_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsss_scan_core
// Scan state registers and the step update: bottom motor sweep,
// turnaround onto the top motor, direction flip and end-of-scan detection.
// ----------------------------------------------------------------------------
module tsss_scan_core
	import tsss_pkg::*;
#(
	parameter int POS_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [SWEEP_LIM_W-1:0] sweep_limit,
	input  wire logic [ROW_LIM_W-1:0]   row_limit,
	output      logic [POS_BITS-1:0]    sweep_pos_q,
	output      logic [POS_BITS-1:0]    row_pos_q,
	output      scan_flags_t            flags_q
);

	logic [POS_BITS-1:0] pos_lim;
	logic [POS_BITS-1:0] neg_lim;
	logic [POS_BITS-1:0] row_lim;
	logic [POS_BITS-1:0] row_nxt;
	logic                at_lim;
	logic                turn;
	logic                move;

	assign pos_lim = POS_BITS'(sweep_limit);
	assign neg_lim = POS_BITS'(~pos_lim + 1'b1);
	assign row_lim = POS_BITS'(row_limit);
	assign row_nxt = POS_BITS'(row_pos_q + 1'b1);

	assign at_lim = flags_q.moving_right ? (sweep_pos_q == pos_lim) : (sweep_pos_q == neg_lim);
	assign turn   = step && !flags_q.finished && at_lim;
	assign move   = step && !flags_q.finished && !at_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_pos_q          <= '0;
			row_pos_q            <= '0;
			flags_q.moving_right <= 1'b1;
			flags_q.finished     <= 1'b0;
			flags_q.bottom_phase <= '0;
			flags_q.top_phase    <= '0;
		end else if (turn) begin
			// step the top motor and reverse the sweep
			row_pos_q            <= row_nxt;
			flags_q.top_phase    <= PHASE_W'(flags_q.top_phase + 1'b1);
			flags_q.moving_right <= !flags_q.moving_right;
			flags_q.finished     <= (row_nxt == row_lim);
		end else if (move) begin
			if (flags_q.moving_right) begin
				sweep_pos_q          <= POS_BITS'(sweep_pos_q + 1'b1);
				flags_q.bottom_phase <= PHASE_W'(flags_q.bottom_phase + 1'b1);
			end else begin
				sweep_pos_q          <= POS_BITS'(sweep_pos_q - 1'b1);
				flags_q.bottom_phase <= PHASE_W'(flags_q.bottom_phase - 1'b1);
			end
		end
	end

	a_turn_flips_dir: assert property (@(posedge clk) disable iff (!arst_n)
		turn |=> flags_q.moving_right != $past(flags_q.moving_right))
		else $error("turnaround did not reverse the sweep");

	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.finished |=> flags_q.finished)
		else $error("finished flag dropped");

	a_done_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.finished |=> $stable(sweep_pos_q) && $stable(row_pos_q)
			&& $stable(flags_q.bottom_phase) && $stable(flags_q.top_phase))
		else $error("state moved after the scan finished");

	a_move_keeps_row: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> $stable(row_pos_q) && $stable(flags_q.top_phase)
			&& $stable(flags_q.moving_right))
		else $error("bottom step disturbed the top motor");

endmodule
`default_nettype wire

// File: hw/rtl/two_axis_serpentine_stepper_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_axis_serpentine_stepper_scan
// Serpentine raster sequencer for two four-phase stepper motors.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result, valid in the cycle after
// acceptance; one item is taken per clock as long as the previous result is
// taken in the same cycle. The scan state registers double as the result
// register, so the step update (one compare against the sweep limit and one
// increment) sets the cycle. Coil outputs show the pattern register selected
// by each motor's current phase. Configuration is written through cfg_we,
// cfg_index and cfg_data; writes to indexes above five are dropped.
// ----------------------------------------------------------------------------
module two_axis_serpentine_stepper_scan
	import tsss_pkg::*;
#(
	parameter int POS_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output      logic                   in_ready,
	input  wire logic                   go,
	output      logic                   out_valid,
	input  wire logic                   out_ready,
	output      logic [COIL_W-1:0]      bottom_coils,
	output      logic [COIL_W-1:0]      top_coils,
	output      logic signed [POS_OUT_W-1:0] sweep_position,
	output      logic [POS_OUT_W-1:0]   row_position,
	output      logic                   moving_right,
	output      logic                   finished
);

	logic [COIL_W-1:0]      pattern_q [4];
	logic [SWEEP_LIM_W-1:0] sweep_limit_q;
	logic [ROW_LIM_W-1:0]   row_limit_q;
	logic                   out_valid_q;
	logic                   accept;
	logic [POS_BITS-1:0]    sweep_pos;
	logic [POS_BITS-1:0]    row_pos;
	scan_flags_t            flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q[0]  <= PATTERN0_RST;
			pattern_q[1]  <= PATTERN1_RST;
			pattern_q[2]  <= PATTERN2_RST;
			pattern_q[3]  <= PATTERN3_RST;
			sweep_limit_q <= SWEEP_LIMIT_RST;
			row_limit_q   <= ROW_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN0:    pattern_q[0]  <= cfg_data[COIL_W-1:0];
				REG_PATTERN1:    pattern_q[1]  <= cfg_data[COIL_W-1:0];
				REG_PATTERN2:    pattern_q[2]  <= cfg_data[COIL_W-1:0];
				REG_PATTERN3:    pattern_q[3]  <= cfg_data[COIL_W-1:0];
				REG_SWEEP_LIMIT: sweep_limit_q <= cfg_data[SWEEP_LIM_W-1:0];
				REG_ROW_LIMIT:   row_limit_q   <= cfg_data[ROW_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// take a new beat when no result is held or the held result leaves this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	tsss_scan_core #(
		.POS_BITS (POS_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept && go),
		.sweep_limit (sweep_limit_q),
		.row_limit   (row_limit_q),
		.sweep_pos_q (sweep_pos),
		.row_pos_q   (row_pos),
		.flags_q     (flags)
	);

	assign out_valid      = out_valid_q;
	assign bottom_coils   = pattern_q[flags.bottom_phase];
	assign top_coils      = pattern_q[flags.top_phase];
	assign sweep_position = POS_OUT_W'(signed'(sweep_pos));
	assign row_position   = POS_OUT_W'(row_pos);
	assign moving_right   = flags.moving_right;
	assign finished       = flags.finished;

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(sweep_position)
			&& $stable(row_position) && $stable(finished))
		else $error("result changed while stalled");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted beat produced no result");

	a_no_result_unasked: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> !out_valid_q)
		else $error("result appeared without an accepted beat");

endmodule
`default_nettype wire

// File: tb/sv/serpentine_scan_tb_pkg.sv
// ----------------------------------------------------------------------------
// Serpentine scan scoreboard
// Tracks the scan state of both motors beat by beat, queues the status each
// accepted request should report and compares it with the returned results.
// ----------------------------------------------------------------------------
package serpentine_scan_tb_pkg;

	import tsss_pkg::*;

	typedef struct packed {
		logic [COIL_W-1:0]    bottom_coils;
		logic [COIL_W-1:0]    top_coils;
		logic [POS_OUT_W-1:0] sweep_position;
		logic [POS_OUT_W-1:0] row_position;
		logic                 moving_right;
		logic                 finished;
	} scan_report_t;

	localparam int REPORT_LIMIT = 10;

	class scan_scoreboard;
		logic [COIL_W-1:0]      pattern [4];
		logic [SWEEP_LIM_W-1:0] sweep_limit;
		logic [ROW_LIM_W-1:0]   row_limit;
		logic [POS_OUT_W-1:0]   sweep_pos;
		logic [POS_OUT_W-1:0]   row_pos;
		logic                   dir_right;
		logic                   done;
		logic [PHASE_W-1:0]     bottom_phase;
		logic [PHASE_W-1:0]     top_phase;
		scan_report_t           awaited [$];
		int                     errors;
		int                     beats;
		int                     steps;
		int                     rows_stepped;
		int                     checked;

		function new();
			pattern      = '{PATTERN0_RST, PATTERN1_RST, PATTERN2_RST, PATTERN3_RST};
			sweep_limit  = SWEEP_LIMIT_RST;
			row_limit    = ROW_LIMIT_RST;
			sweep_pos    = '0;
			row_pos      = '0;
			dir_right    = 1'b1;
			done         = 1'b0;
			bottom_phase = '0;
			top_phase    = '0;
			errors       = 0;
			beats        = 0;
			steps        = 0;
			rows_stepped = 0;
			checked      = 0;
		endfunction

		function int sweep_signed();
			return int'($signed(sweep_pos));
		endfunction

		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PATTERN0:    pattern[0] = data[COIL_W-1:0];
				REG_PATTERN1:    pattern[1] = data[COIL_W-1:0];
				REG_PATTERN2:    pattern[2] = data[COIL_W-1:0];
				REG_PATTERN3:    pattern[3] = data[COIL_W-1:0];
				REG_SWEEP_LIMIT: sweep_limit = data[SWEEP_LIM_W-1:0];
				REG_ROW_LIMIT:   row_limit = data[ROW_LIM_W-1:0];
				default: ;
			endcase
		endfunction

		// Turn around on an exact match with the limit pattern, otherwise walk on.
		function void advance_scan();
			logic [POS_OUT_W-1:0] pos_lim;
			logic [POS_OUT_W-1:0] neg_lim;
			pos_lim = POS_OUT_W'(sweep_limit);
			neg_lim = POS_OUT_W'(0) - pos_lim;
			if (done)
				return;
			steps++;
			if (dir_right ? (sweep_pos == pos_lim) : (sweep_pos == neg_lim)) begin
				top_phase++;
				row_pos++;
				rows_stepped++;
				dir_right = !dir_right;
				if (row_pos == row_limit)
					done = 1'b1;
			end else if (dir_right) begin
				bottom_phase++;
				sweep_pos++;
			end else begin
				bottom_phase--;
				sweep_pos--;
			end
		endfunction

		function void note_request(logic go_bit);
			beats++;
			if (go_bit)
				advance_scan();
			awaited.push_back('{
				bottom_coils:   pattern[bottom_phase],
				top_coils:      pattern[top_phase],
				sweep_position: sweep_pos,
				row_position:   row_pos,
				moving_right:   dir_right,
				finished:       done
			});
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("mismatch: %s", what);
		endfunction

		function void check_status(scan_report_t got);
			scan_report_t want;
			string        diff;
			checked++;
			if (awaited.size() == 0) begin
				flag($sformatf("result %0d arrived with nothing awaited (%h)", checked, got));
				return;
			end
			want = awaited.pop_front();
			diff = "";
			if (got.bottom_coils !== want.bottom_coils)
				diff = {diff, $sformatf(" bottom_coils %h/%h", want.bottom_coils, got.bottom_coils)};
			if (got.top_coils !== want.top_coils)
				diff = {diff, $sformatf(" top_coils %h/%h", want.top_coils, got.top_coils)};
			if (got.sweep_position !== want.sweep_position)
				diff = {diff, $sformatf(" sweep_position %0d/%0d",
					$signed(want.sweep_position), $signed(got.sweep_position))};
			if (got.row_position !== want.row_position)
				diff = {diff, $sformatf(" row_position %0d/%0d", want.row_position,
					got.row_position)};
			if (got.moving_right !== want.moving_right)
				diff = {diff, $sformatf(" moving_right %b/%b", want.moving_right, got.moving_right)};
			if (got.finished !== want.finished)
				diff = {diff, $sformatf(" finished %b/%b", want.finished, got.finished)};
			if (diff != "")
				flag($sformatf("result %0d, expected/actual:%s", checked, diff));
		endfunction
	endclass

endpackage

// File: tb/sv/two_axis_serpentine_stepper_scan_tb.sv
// ----------------------------------------------------------------------------
// two_axis_serpentine_stepper_scan_tb
// Walks the sequencer through a serpentine scan: directed steps at the
// register extremes, random sweeps with small limits under every idling mix,
// the bottom motor walking on past a lowered limit and a run to the scan end.
// ----------------------------------------------------------------------------
module two_axis_serpentine_stepper_scan_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import tsss_pkg::*;
	import serpentine_scan_tb_pkg::*;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES = 64;
	localparam int QUIET_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  go = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [COIL_W-1:0]     bottom_coils;
	logic [COIL_W-1:0]     top_coils;
	logic signed [POS_OUT_W-1:0] sweep_position;
	logic [POS_OUT_W-1:0]  row_position;
	logic                  moving_right;
	logic                  finished;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_seq = 0;
	int quiet_cycles = 0;

	scan_scoreboard sb;

	two_axis_serpentine_stepper_scan i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.go             (go),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.bottom_coils   (bottom_coils),
		.top_coils      (top_coils),
		.sweep_position (sweep_position),
		.row_position   (row_position),
		.moving_right   (moving_right),
		.finished       (finished)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Check the result beat before noting the request beat of the same edge.
	always @(posedge clk) begin
		scan_report_t got;
		if (out_valid && out_ready) begin
			got.bottom_coils   = bottom_coils;
			got.top_coils      = top_coils;
			got.sweep_position = sweep_position;
			got.row_position   = row_position;
			got.moving_right   = moving_right;
			got.finished       = finished;
			sb.check_status(got);
		end
		if (in_valid && in_ready)
			sb.note_request(go);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idling(input idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 79; recv_stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 79; end
			IDLE_BOTH: begin send_idle_pct = 14; recv_stall_pct = 14; end
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.apply_write(idx, data);
		@(posedge clk);
	endtask

	task automatic send_beat(input logic go_bit);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		go       <= go_bit;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_run(input int n, input logic go_bit);
		for (int i = 0; i < n; i++)
			send_beat(go_bit);
	endtask

	// Drop valid and wait for every outstanding result, checked between edges.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.awaited.size() != 0);
		@(posedge clk);
	endtask

	task automatic run_burst(input int n, input int go_pct, input bit with_pause,
			input bit with_hold);
		for (int i = 0; i < n; i++) begin
			if (with_pause && i == n / 2)
				settle();
			if (with_hold && i == n / 4)
				hold_seq <= hold_seq + 1;
			send_beat($urandom_range(0, 99) < go_pct);
		end
		settle();
	endtask

	// Keep the sweep limit at or beyond the current position so no wrap starts here.
	task automatic reconfigure();
		int pos;
		int lim;
		pos = sb.sweep_signed();
		lim = $urandom_range(0, 6);
		if (lim < pos)
			lim = pos;
		if (lim < -pos)
			lim = -pos;
		for (int i = 0; i < 4; i++)
			if ($urandom_range(0, 1))
				write_reg(CFG_IDX_W'(int'(REG_PATTERN0) + i), CFG_DATA_W'($urandom_range(0, 4095)));
		write_reg(REG_SWEEP_LIMIT, CFG_DATA_W'(lim));
		write_reg(REG_ROW_LIMIT, CFG_DATA_W'($urandom_range(2048, 4095)));
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
				CFG_DATA_W'($urandom_range(0, 4095)));
	endtask

	initial begin
		int lead;
		int turn_at;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset patterns, register extremes, turnarounds, zero limit.
		set_idling(IDLE_NONE);
		send_beat(1'b0);
		send_run(3, 1'b1);
		settle();
		write_reg(REG_ROW_LIMIT, 12'hFFF);
		write_reg(REG_PATTERN0, 12'hFFF);
		write_reg(REG_PATTERN1, 12'h000);
		write_reg(REG_PATTERN2, 12'h5AA);
		write_reg(REG_PATTERN3, 12'hA55);
		send_beat(1'b0);
		send_beat(1'b1);
		settle();
		write_reg(REG_SWEEP_LIMIT, 12'h7FF);
		send_run(2, 1'b1);
		settle();
		write_reg(REG_SWEEP_LIMIT, 12'd6);
		send_run(2, 1'b1);
		settle();
		write_reg(REG_SWEEP_LIMIT, 12'd0);
		send_run(7, 1'b1);
		send_beat(1'b0);
		settle();
		write_reg(REG_SPARE_LO, 12'hFFF);
		write_reg(REG_SPARE_HI, 12'hFFF);
		send_beat(1'b1);
		settle();

		// Random sweeps with small limits, every idling mix in turn.
		for (int k = 0; k < 8; k++) begin
			reconfigure();
			set_idling(idle_mode_e'(k % 4));
			run_burst(80, 85, (k % 4) == 1, (k % 4) == 0);
		end

		// Step clear of a lowered limit so the bottom motor walks on past it.
		write_reg(REG_SWEEP_LIMIT, 12'h7FF);
		lead = sb.dir_right ? 2 - sb.sweep_signed() : sb.sweep_signed() + 2;
		if (lead > 0)
			send_run(lead, 1'b1);
		settle();
		write_reg(REG_SWEEP_LIMIT, 12'd1);
		set_idling(IDLE_SEND);
		send_run(6, 1'b1);
		settle();
		// Move the limit onto the position reached so the next step turns round.
		turn_at = sb.sweep_signed();
		if (turn_at < 0)
			turn_at = -turn_at;
		write_reg(REG_SWEEP_LIMIT, CFG_DATA_W'(turn_at));
		run_burst(30, 70, 1'b0, 1'b0);

		// Centre the sweep, then step the top motor up to the row limit.
		set_idling(IDLE_NONE);
		while (sb.sweep_pos != '0) begin
			send_beat(1'b1);
			settle();
		end
		write_reg(REG_SWEEP_LIMIT, 12'd0);
		write_reg(REG_ROW_LIMIT, CFG_DATA_W'(int'(sb.row_pos) + 6));
		set_idling(IDLE_BOTH);
		send_run(10, 1'b1);
		run_burst(40, 60, 1'b0, 1'b0);

		repeat (4) @(posedge clk);
		$display("scan run: %0d request beats, %0d results checked, %0d steps, %0d row steps",
			sb.beats, sb.checked, sb.steps, sb.rows_stepped);
		$display("limit extremes and walking past a lowered limit covered; scan end %s; %0d mismatches",
			sb.done ? "reached" : "missed", sb.errors);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
